/* hdl/ufd_pkg.sv */
// package for the length-framed uart byte receiver
// holds store sizing, event codes, register indexes and shared structs; no dependencies
`timescale 1ns / 1ps

package ufd_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = 9;
  localparam int BYTE_W      = 8;
  localparam int CFG_IW      = 2;
  localparam int CFG_DW      = 8;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_START    = 3'd1,
    EV_LENGTH   = 3'd2,
    EV_STORED   = 3'd3,
    EV_COMPLETE = 3'd4,
    EV_ABORT    = 3'd5,
    EV_READ     = 3'd6
  } ev_t;

  localparam logic [CFG_IW-1:0] CFG_START_BYTE = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_END_BYTE   = CFG_IW'(1);

  // per-item result leaving the control stage
  typedef struct packed {
    ev_t              ev;
    logic [CNT_W-1:0] flen;
    logic             rd_ok;
  } ufd_res_t;

  // finished result as presented on the output channel
  typedef struct packed {
    ev_t               ev;
    logic [CNT_W-1:0]  flen;
    logic [BYTE_W-1:0] rdata;
  } ufd_item_t;

  // payload store access request
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [BYTE_W-1:0]   wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } ufd_memreq_t;

endpackage

/* hdl/ufd_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ufd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ufd_ctrl.sv */
// frame rules: start/length/end byte decode, byte counter and store access
// depends on ufd_pkg
`timescale 1ns / 1ps

module ufd_ctrl
  import ufd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              acc,
  input  logic              cmd,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] read_index,
  output ufd_res_t          res,
  output ufd_memreq_t       memreq
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

  logic [BYTE_W-1:0] start_byte_r;
  logic [BYTE_W-1:0] end_byte_r;
  logic              coll_r, coll_nxt;
  logic [BYTE_W-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  exp_w;

  assign exp_w = {1'b0, exp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= '0;
      end_byte_r   <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_START_BYTE) begin
        start_byte_r <= cfg_wdata[BYTE_W-1:0];
      end else if (cfg_index == CFG_END_BYTE) begin
        end_byte_r <= cfg_wdata[BYTE_W-1:0];
      end
    end
  end

  always_comb begin
    coll_nxt     = coll_r;
    exp_nxt      = exp_r;
    cnt_nxt      = cnt_r;
    res.ev       = EV_NONE;
    res.rd_ok    = 1'b0;
    memreq.we    = 1'b0;
    memreq.waddr = cnt_r[STORE_AW-1:0];
    memreq.wdata = rx_byte;
    memreq.re    = 1'b0;
    memreq.raddr = read_index[STORE_AW-1:0];
    if (acc) begin
      if (cmd) begin
        res.ev    = EV_READ;
        memreq.re = 1'b1;
        res.rd_ok = ({1'b0, read_index} < DEPTH_C);
      end else if (rx_byte == start_byte_r && exp_r == '0) begin
        coll_nxt = 1'b1;
        cnt_nxt  = '0;
        res.ev   = EV_START;
      end else if (exp_r == '0 && coll_r) begin
        exp_nxt = rx_byte;
        res.ev  = EV_LENGTH;
      end else if (rx_byte == end_byte_r && exp_w == cnt_r) begin
        coll_nxt = 1'b0;
        exp_nxt  = '0;
        res.ev   = EV_COMPLETE;
      end else if (cnt_r > exp_w) begin
        coll_nxt = 1'b0;
        exp_nxt  = '0;
        res.ev   = EV_ABORT;
      end else if (coll_r) begin
        // writes past the store are dropped, the count still advances
        memreq.we = (cnt_r < DEPTH_C);
        if (cnt_r != '1) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        res.ev = EV_STORED;
      end else begin
        exp_nxt = '0;
      end
    end
    res.flen = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coll_r <= 1'b0;
      exp_r  <= '0;
      cnt_r  <= '0;
    end else begin
      coll_r <= coll_nxt;
      exp_r  <= exp_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* hdl/ufd_outq.sv */
// result pipeline: ram read stage, output register and skid register
// depends on ufd_pkg
`timescale 1ns / 1ps

module ufd_outq
  import ufd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ufd_res_t          res,
  input  logic [BYTE_W-1:0] ram_q,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output ufd_item_t         out_item
);

  logic      s1_valid_r, s1_valid_nxt;
  ufd_res_t  s1_res_r, s1_res_nxt;
  logic      out_valid_r, out_valid_nxt;
  ufd_item_t out_r, out_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  ufd_item_t skid_r, skid_nxt;
  ufd_item_t s1_item;
  logic      out_free;
  logic      s1_mv;

  // ram data lines up with the stage-1 result; it holds while no read is issued
  always_comb begin
    s1_item.ev    = s1_res_r.ev;
    s1_item.flen  = s1_res_r.flen;
    s1_item.rdata = s1_res_r.rd_ok ? ram_q : '0;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_mv    = s1_valid_r && !skid_valid_r;
  assign full     = s1_valid_r && skid_valid_r;

  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    s1_res_nxt     = s1_res_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;

    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else if (s1_mv) begin
        out_valid_nxt = 1'b1;
        out_nxt       = s1_item;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (s1_mv) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = s1_item;
    end

    if (push) begin
      s1_valid_nxt = 1'b1;
      s1_res_nxt   = res;
    end else if (s1_mv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_res_r <= s1_res_nxt;
    out_r    <= out_nxt;
    skid_r   <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* hdl/uart_length_framed_deframer_top.sv */
// length-framed uart byte receiver, top level
// accepted items are registered in the read stage, then in the output or skid register
// throughput: one item per cycle unless in_stall; store ram: one write, one read port
// in_stall rises only when the read stage and the skid register both hold a result
// reset (rst_n low, synchronous) clears frame state, config registers and all valid bits;
// the payload store is not cleared and reads of never-written entries are undefined
`timescale 1ns / 1ps

module uart_length_framed_deframer_top
  import ufd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [7:0]        in_rx_byte,
  input  logic [7:0]        in_read_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_event_res,
  output logic [8:0]        out_frame_length,
  output logic [7:0]        out_read_data
);

  logic              acc;
  ufd_res_t          res;
  ufd_memreq_t       memreq;
  logic [BYTE_W-1:0] ram_q;
  logic              full;
  ufd_item_t         out_item;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  ufd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .acc        (acc),
    .cmd        (in_cmd),
    .rx_byte    (in_rx_byte),
    .read_index (in_read_index),
    .res        (res),
    .memreq     (memreq)
  );

  ufd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH),
    .AW    (STORE_AW)
  ) u_store (
    .clk   (clk),
    .we    (memreq.we),
    .waddr (memreq.waddr),
    .wdata (memreq.wdata),
    .re    (memreq.re),
    .raddr (memreq.raddr),
    .rdata (ram_q)
  );

  ufd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .res       (res),
    .ram_q     (ram_q),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_event_res    = out_item.ev;
  assign out_frame_length = out_item.flen;
  assign out_read_data    = out_item.rdata;

`ifndef SYNTH
  // a full pipeline means the output register is occupied
  a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall high with no result on the output");

  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != EV_READ) |-> (out_read_data == '0))
    else $error("read data nonzero on a receive result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_length <= CNT_W'(STORE_DEPTH)))
    else $error("frame length beyond store depth");

  a_write_only_stored: assert property (@(posedge clk) disable iff (!rst_n)
    memreq.we |-> (acc && !in_cmd && res.ev == EV_STORED))
    else $error("store write without a stored byte");
`endif

endmodule

/* test/ufd_result_checker.sv */
// result checker for the length-framed uart byte receiver
// tracks config writes and accepted items, predicts each result and compares; needs ufd_pkg
`timescale 1ns / 1ps

module ufd_result_checker
  import ufd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_cmd,
  input  logic [7:0]        in_rx_byte,
  input  logic [7:0]        in_read_index,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        out_event_res,
  input  logic [8:0]        out_frame_length,
  input  logic [7:0]        out_read_data,
  output int                fail_count,
  output int                pending
);

  logic [7:0]       start_code;
  logic [7:0]       end_code;
  logic             in_frame;
  logic [7:0]       want_len;
  logic [CNT_W-1:0] got_cnt;
  logic [7:0]       payload_mem [STORE_DEPTH];
  ufd_item_t        expected_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // frame rules are tried in priority order, first match wins
  function automatic ufd_item_t deframe_step(input logic cmd, input logic [7:0] b,
                                             input logic [7:0] idx);
    ufd_item_t r;
    r.ev    = EV_NONE;
    r.rdata = '0;
    if (cmd) begin
      r.ev = EV_READ;
      if (int'(idx) < STORE_DEPTH) r.rdata = payload_mem[idx];
    end else if (b == start_code && want_len == 8'd0) begin
      in_frame = 1'b1;
      got_cnt  = '0;
      r.ev     = EV_START;
    end else if (want_len == 8'd0 && in_frame) begin
      want_len = b;
      r.ev     = EV_LENGTH;
    end else if (b == end_code && {1'b0, want_len} == got_cnt) begin
      in_frame = 1'b0;
      want_len = 8'd0;
      r.ev     = EV_COMPLETE;
    end else if (got_cnt > {1'b0, want_len}) begin
      in_frame = 1'b0;
      want_len = 8'd0;
      r.ev     = EV_ABORT;
    end else if (in_frame) begin
      if (int'(got_cnt) < STORE_DEPTH) payload_mem[got_cnt[7:0]] = b;
      if (got_cnt != '1) got_cnt = got_cnt + 1'b1;
      r.ev = EV_STORED;
    end else begin
      want_len = 8'd0;
    end
    r.flen = got_cnt;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    ufd_item_t got;
    ufd_item_t want;
    if (!rst_n) begin
      start_code = 8'd0;
      end_code   = 8'd0;
      in_frame   = 1'b0;
      want_len   = 8'd0;
      got_cnt    = '0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_START_BYTE: start_code = cfg_wdata[7:0];
          CFG_END_BYTE:   end_code   = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.ev    = ev_t'(out_event_res);
        got.flen  = out_frame_length;
        got.rdata = out_read_data;
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result ev %0d len %0d data %0d",
                     $time, got.ev, got.flen, got.rdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.ev !== want.ev || got.flen !== want.flen || got.rdata !== want.rdata) begin
            if (fail_count < 10)
              $display("%0t: mismatch ev %0d/%0d len %0d/%0d data %0d/%0d (exp/got)",
                       $time, want.ev, got.ev, want.flen, got.flen, want.rdata, got.rdata);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(deframe_step(in_cmd, in_rx_byte, in_read_index));
    end
    pending = expected_results.size();
  end

endmodule

/* test/tb.sv */
// testbench top for the length-framed uart byte receiver
// drives framed byte streams, store reads and framing config; uses ufd_pkg and ufd_result_checker
`timescale 1ns / 1ps

module tb;
  import ufd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 140;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic              in_cmd;
  logic [7:0]        in_rx_byte;
  logic [7:0]        in_read_index;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        out_event_res;
  logic [8:0]        out_frame_length;
  logic [7:0]        out_read_data;

  int         fail_count;
  int         pending;
  int         cycle_cnt = 0;
  int         items_sent = 0;
  bit         quiet = 1'b0;
  logic [7:0] sob;
  logic [7:0] eob;

  uart_length_framed_deframer_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_rx_byte       (in_rx_byte),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_frame_length (out_frame_length),
    .out_read_data    (out_read_data)
  );

  ufd_result_checker frame_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_rx_byte       (in_rx_byte),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_frame_length (out_frame_length),
    .out_read_data    (out_read_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver back-pressure in short bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic push_item(input logic cmd, input logic [7:0] b, input logic [7:0] idx);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_rx_byte    <= b;
    in_read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic rx(input logic [7:0] b);
    push_item(1'b0, b, 8'($urandom));
  endtask

  task automatic rd(input logic [7:0] idx);
    push_item(1'b1, 8'($urandom), idx);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_framing(input logic [7:0] s, input logic [7:0] e);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_START_BYTE;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_index <= CFG_END_BYTE;
    cfg_wdata <= e;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sob = s;
    eob = e;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return sob;
      1:       return eob;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed frames with random content, some broken ones, noise and reads
  task automatic frame_mix();
    int kind;
    int len;
    int n;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 4)) rx(pick_byte());
    end else if (kind == 1) begin
      repeat ($urandom_range(1, 3)) rd(8'($urandom));
    end else begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      n = len;
      if (kind == 2) n = len + $urandom_range(0, 4) - 2;
      if (n < 0) n = 0;
      rx(sob);
      if ($urandom_range(0, 7) == 0) rx(8'h00);
      rx(len[7:0]);
      for (int i = 0; i < n; i++)
        rx(($urandom_range(0, 3) == 0) ? pick_byte() : 8'($urandom));
      rx((kind == 3) ? pick_byte() : eob);
      if ($urandom_range(0, 3) == 0) rd(8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] phase_sob [5];
    logic [7:0] phase_eob [5];
    int         phase_end;
    phase_sob = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'($urandom)};
    phase_eob = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'($urandom)};
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_START_BYTE;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_cmd        = 1'b0;
    in_rx_byte    = 8'd0;
    in_read_index = 8'd0;
    sob           = 8'd0;
    eob           = 8'd0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_framing(8'hA5, 8'h5A);
    // end byte with no frame open and count still zero reports complete
    rx(8'h5A);
    rx(8'h00);
    rx(8'hFF);
    // longest frame fills every store entry before anything is read
    rx(8'hA5);
    rx(8'hFF);
    for (int i = 0; i < 256; i++)
      rx((i == 255) ? 8'h00 : ((i == 0) ? 8'hFF : 8'($urandom)));
    rx(8'h00);
    rx(8'h5A);
    rd(8'h00);
    rd(8'hFF);
    rd(8'hAA);
    rd(8'h55);
    // zero length byte keeps waiting for a length
    rx(8'hA5);
    rx(8'h00);
    rx(8'h02);
    rx(8'h11);
    rx(8'h22);
    rx(8'h5A);
    // count holds after complete
    rx(8'h33);
    // one byte too many, then abort
    rx(8'hA5);
    rx(8'h01);
    rx(8'h07);
    rx(8'h08);
    rx(8'h09);
    // start and end codes carried as payload
    rx(8'hA5);
    rx(8'h02);
    rx(8'hA5);
    rx(8'h5A);
    rx(8'h5A);
    rd(8'h01);

    for (int ph = 0; ph < 5; ph++) begin
      set_framing(phase_sob[ph], phase_eob[ph]);
      if (ph == 4) quiet = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) frame_mix();
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
